// File: rtl/websocket_frame_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL files.
// Depends on nothing; the asserting modules must have ports named clock and reset.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define WSDF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every edge, reset included.
`define WSDF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define WSDF_ASSERT(label, prop, msg)
`define WSDF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/wsdf_pkg.sv
// Shared types, widths and codes of the WebSocket frame deframer.
// Depends on nothing; used by every RTL module of the block.
package wsdf_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 31;
   localparam int OPC_W      = 4;
   localparam int RSV_W      = 3;
   localparam int ERR_W      = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;
   localparam int KEY_BYTES  = 4;
   localparam int KEY_IDX_W  = 2;
   localparam int BCNT_W     = 3;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECT_MASKED = 1'b1;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST   = 31'd65536;
   localparam logic             EXPECT_MASKED_RST = 1'b1;

   typedef logic [ERR_W-1:0] err_type;
   localparam err_type ERR_NONE   = 2'd0;
   localparam err_type ERR_MASK   = 2'd1;
   localparam err_type ERR_LONG   = 2'd2;
   localparam err_type ERR_OPCODE = 2'd3;

   localparam logic [OPC_W-1:0] OPC_CONT   = 4'd0;
   localparam logic [OPC_W-1:0] OPC_TEXT   = 4'd1;
   localparam logic [OPC_W-1:0] OPC_BINARY = 4'd2;
   localparam logic [OPC_W-1:0] OPC_CLOSE  = 4'd8;
   localparam logic [OPC_W-1:0] OPC_PING   = 4'd9;
   localparam logic [OPC_W-1:0] OPC_PONG   = 4'd10;

   // Seven-bit length codes that announce an extended length field.
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [BCNT_W-1:0] LEN16_LAST = 3'd1;
   localparam logic [BCNT_W-1:0] LEN64_LAST = 3'd7;

   typedef enum logic [6:0] {
      PH_FIRST   = 7'b0000001,
      PH_SECOND  = 7'b0000010,
      PH_LEN16   = 7'b0000100,
      PH_LEN64   = 7'b0001000,
      PH_KEY     = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_HALT    = 7'b1000000
   } phase_type;

   // One classified request on its way from the parser to the output stage.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_val;
      logic [BYTE_W-1:0] key;
      logic              masked;
      logic              data_valid;
      logic              frame_end;
      logic [OPC_W-1:0]  opcode;
      logic              fin;
      logic [RSV_W-1:0]  rsv;
      err_type           error_code;
   } item_type;

   function automatic logic opcode_ok(input logic [OPC_W-1:0] opc);
      return (opc == OPC_CONT) || (opc == OPC_TEXT) || (opc == OPC_BINARY) ||
             (opc == OPC_CLOSE) || (opc == OPC_PING) || (opc == OPC_PONG);
   endfunction

endpackage

// File: rtl/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer: configuration registers and the three stages.
// Depends on wsdf_pkg, wsdf_front, wsdf_fifo, wsdf_back.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_byte_in
//   rsp      out        rsp_valid/rsp_stall  data, flags, opcode, fin, rsv, error_code
//   csr      in         csr_write            csr_index, csr_wdata
//
// One request is taken every cycle while the two-entry queue has room; the parser
// classifies it combinationally, and each result that it produces takes a queue slot
// and then the output register.
// Synchronous active-high reset returns the parser to the first header byte and
// empties the queue; it also restores the two configuration registers.
// A stalled result holds in the output register while the queue keeps filling.
module websocket_frame_deframer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wsdf_pkg::BYTE_W-1:0]       req_byte_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wsdf_pkg::BYTE_W-1:0]       rsp_data,
   output logic                              rsp_data_valid,
   output logic                              rsp_frame_end,
   output logic [wsdf_pkg::OPC_W-1:0]        rsp_opcode,
   output logic                              rsp_fin,
   output logic [wsdf_pkg::RSV_W-1:0]        rsp_rsv,
   output logic [wsdf_pkg::ERR_W-1:0]        rsp_error_code,
   input  logic                              csr_write,
   input  logic [wsdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wsdf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wsdf_pkg::*;

   logic [LEN_W-1:0]  max_payload_ff, max_payload_in;
   logic              expect_masked_ff, expect_masked_in;
   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;
   item_type          push_item;
   item_type          pop_item;

   always_comb begin
      max_payload_in   = max_payload_ff;
      expect_masked_in = expect_masked_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:   max_payload_in   = csr_wdata[LEN_W-1:0];
            CSR_EXPECT_MASKED: expect_masked_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff   <= MAX_PAYLOAD_RST;
         expect_masked_ff <= EXPECT_MASKED_RST;
      end else begin
         max_payload_ff   <= max_payload_in;
         expect_masked_ff <= expect_masked_in;
      end
   end

   assign req_stall = q_full;

   wsdf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_byte_in   (req_byte_in),
      .q_full        (q_full),
      .max_payload   (max_payload_ff),
      .expect_masked (expect_masked_ff),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   wsdf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   wsdf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .rsp_data_valid (rsp_data_valid),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_opcode     (rsp_opcode),
      .rsp_fin        (rsp_fin),
      .rsp_rsv        (rsp_rsv),
      .rsp_error_code (rsp_error_code)
   );

endmodule

// File: rtl/wsdf_front.sv
// Header parser: walks the frame header, holds length and mask key, classifies bytes.
// Depends on wsdf_pkg and the assertion macro header.
`include "websocket_frame_deframer_core_defines.svh"

module wsdf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [wsdf_pkg::BYTE_W-1:0]   req_byte_in,
   input  logic                          q_full,
   input  logic [wsdf_pkg::LEN_W-1:0]    max_payload,
   input  logic                          expect_masked,
   output logic                          q_push,
   output wsdf_pkg::item_type            q_item
);
   import wsdf_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  fin_ff, fin_in;
   logic [RSV_W-1:0]      rsv_ff, rsv_in;
   logic [OPC_W-1:0]      opc_ff, opc_in;
   logic                  mask_ff, mask_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic                  ovf_ff, ovf_in;
   logic [BCNT_W-1:0]     bcnt_ff, bcnt_in;
   logic [KEY_IDX_W-1:0]  kidx_ff, kidx_in;
   logic [BYTE_W-1:0]     key_ff [KEY_BYTES];
   logic                  key_we;
   logic                  accept;

   assign accept = req_valid && !q_full;

   always_comb begin : front_next
      logic                 len_done;
      logic                 len_ovf;
      logic [LEN_W-1:0]     len_val;
      logic                 pay_start;
      logic [LEN_W-1:0]     pay_len;
      logic                 last;

      phase_in  = phase_ff;
      fin_in    = fin_ff;
      rsv_in    = rsv_ff;
      opc_in    = opc_ff;
      mask_in   = mask_ff;
      rem_in    = rem_ff;
      ovf_in    = ovf_ff;
      bcnt_in   = bcnt_ff;
      kidx_in   = kidx_ff;
      key_we    = 1'b0;
      len_done  = 1'b0;
      len_ovf   = 1'b0;
      len_val   = '0;
      pay_start = 1'b0;
      pay_len   = rem_ff;
      last      = 1'b0;
      q_push    = 1'b0;

      q_item.byte_val   = req_byte_in;
      q_item.key        = key_ff[kidx_ff];
      q_item.masked     = mask_ff;
      q_item.data_valid = 1'b0;
      q_item.frame_end  = 1'b0;
      q_item.opcode     = opc_ff;
      q_item.fin        = fin_ff;
      q_item.rsv        = rsv_ff;
      q_item.error_code = ERR_NONE;

      if (accept) begin
         unique case (phase_ff)
            PH_FIRST: begin
               fin_in   = req_byte_in[7];
               rsv_in   = req_byte_in[6:4];
               opc_in   = req_byte_in[3:0];
               rem_in   = '0;
               ovf_in   = 1'b0;
               phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               mask_in = req_byte_in[7];
               bcnt_in = '0;
               rem_in  = '0;
               ovf_in  = 1'b0;
               if (req_byte_in[7] != expect_masked) begin
                  phase_in          = PH_HALT;
                  q_push            = 1'b1;
                  q_item.error_code = ERR_MASK;
               end else if (req_byte_in[6:0] == LEN7_EXT16) begin
                  phase_in = PH_LEN16;
               end else if (req_byte_in[6:0] == LEN7_EXT64) begin
                  phase_in = PH_LEN64;
               end else begin
                  len_done = 1'b1;
                  len_val  = LEN_W'(req_byte_in[6:0]);
               end
            end
            PH_LEN16, PH_LEN64: begin
               // Only 31 bits are kept; anything shifted past them marks the length as too long.
               len_val = {rem_ff[LEN_W-BYTE_W-1:0], req_byte_in};
               len_ovf = ovf_ff || (|rem_ff[LEN_W-1:LEN_W-BYTE_W]);
               rem_in  = len_val;
               ovf_in  = len_ovf;
               if (bcnt_ff == ((phase_ff == PH_LEN16) ? LEN16_LAST : LEN64_LAST)) begin
                  bcnt_in  = '0;
                  len_done = 1'b1;
               end else begin
                  bcnt_in = bcnt_ff + BCNT_W'(1);
               end
            end
            PH_KEY: begin
               key_we = 1'b1;
               if (bcnt_ff[KEY_IDX_W-1:0] == KEY_IDX_W'(KEY_BYTES - 1)) begin
                  bcnt_in   = '0;
                  pay_start = 1'b1;
                  pay_len   = rem_ff;
               end else begin
                  bcnt_in = bcnt_ff + BCNT_W'(1);
               end
            end
            PH_PAYLOAD: begin
               rem_in  = rem_ff - LEN_W'(1);
               kidx_in = kidx_ff + KEY_IDX_W'(1);
               last    = (rem_ff == LEN_W'(1));
               if (opcode_ok(opc_ff)) begin
                  q_push            = 1'b1;
                  q_item.data_valid = 1'b1;
                  q_item.frame_end  = last;
                  if (last) begin
                     phase_in = PH_FIRST;
                  end
               end else if (last) begin
                  // Dropped frame of an unsupported opcode: report it once at its end.
                  phase_in          = PH_HALT;
                  q_push            = 1'b1;
                  q_item.frame_end  = 1'b1;
                  q_item.error_code = ERR_OPCODE;
               end
            end
            PH_HALT: begin
               phase_in = PH_HALT;
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase

         if (len_done) begin
            rem_in = len_val;
            ovf_in = len_ovf;
            if (len_ovf || (len_val > max_payload)) begin
               phase_in          = PH_HALT;
               q_push            = 1'b1;
               q_item.error_code = ERR_LONG;
            end else if (mask_in) begin
               phase_in = PH_KEY;
               bcnt_in  = '0;
            end else begin
               pay_start = 1'b1;
               pay_len   = len_val;
            end
         end

         if (pay_start) begin
            kidx_in = '0;
            if (pay_len != '0) begin
               phase_in = PH_PAYLOAD;
            end else begin
               // Empty frame: the header's last byte closes it.
               q_push           = 1'b1;
               q_item.frame_end = 1'b1;
               if (opcode_ok(opc_ff)) begin
                  phase_in = PH_FIRST;
               end else begin
                  phase_in          = PH_HALT;
                  q_item.error_code = ERR_OPCODE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         fin_ff   <= 1'b0;
         rsv_ff   <= '0;
         opc_ff   <= '0;
         mask_ff  <= 1'b0;
         rem_ff   <= '0;
         ovf_ff   <= 1'b0;
         bcnt_ff  <= '0;
         kidx_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
         rsv_ff   <= rsv_in;
         opc_ff   <= opc_in;
         mask_ff  <= mask_in;
         rem_ff   <= rem_in;
         ovf_ff   <= ovf_in;
         bcnt_ff  <= bcnt_in;
         kidx_ff  <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[bcnt_ff[KEY_IDX_W-1:0]] <= req_byte_in;
      end
   end

   `WSDF_ASSERT(a_halt_sticky, (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT), "halt left before reset")
   `WSDF_ASSERT(a_payload_len, (phase_ff == PH_PAYLOAD) |-> (rem_ff != '0), "payload phase with no bytes left")
   `WSDF_ASSERT(a_push_room, q_push |-> !q_full, "request pushed into a full queue")

endmodule

// File: rtl/wsdf_fifo.sv
// Short queue of classified requests between the parser and the output stage.
// Depends on wsdf_pkg and the assertion macro header.
`include "websocket_frame_deframer_core_defines.svh"

module wsdf_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wsdf_pkg::item_type   push_item,
   input  logic                 pop,
   output wsdf_pkg::item_type   pop_item,
   output logic                 full,
   output logic                 empty
);
   import wsdf_pkg::*;

   item_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]    wptr_ff, wptr_in;
   logic [Q_PTR_W-1:0]    rptr_ff, rptr_in;
   logic [Q_CNT_W-1:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + Q_PTR_W'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + Q_PTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

   `WSDF_ASSERT(a_no_underflow, pop |-> !empty, "pop from an empty queue")
   `WSDF_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")
   `WSDF_ASSERT_ALWAYS(a_reset_empty, reset |=> (cnt_ff == '0), "queue not empty after reset")

endmodule

// File: rtl/wsdf_back.sv
// Output stage: unmasks payload bytes and holds the result register under stall.
// Depends on wsdf_pkg and the assertion macro header.
`include "websocket_frame_deframer_core_defines.svh"

module wsdf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  wsdf_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wsdf_pkg::BYTE_W-1:0]   rsp_data,
   output logic                          rsp_data_valid,
   output logic                          rsp_frame_end,
   output logic [wsdf_pkg::OPC_W-1:0]    rsp_opcode,
   output logic                          rsp_fin,
   output logic [wsdf_pkg::RSV_W-1:0]    rsp_rsv,
   output logic [wsdf_pkg::ERR_W-1:0]    rsp_error_code
);
   import wsdf_pkg::*;

   logic                 valid_ff, valid_in;
   logic [BYTE_W-1:0]    data_ff, data_in;
   logic                 dvalid_ff;
   logic                 fend_ff;
   logic [OPC_W-1:0]     opc_ff;
   logic                 fin_ff;
   logic [RSV_W-1:0]     rsv_ff;
   err_type              err_ff;

   assign q_pop = !q_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      if (!q_item.data_valid) begin
         data_in = '0;
      end else if (q_item.masked) begin
         data_in = q_item.byte_val ^ q_item.key;
      end else begin
         data_in = q_item.byte_val;
      end
      if (q_pop) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff   <= data_in;
         dvalid_ff <= q_item.data_valid;
         fend_ff   <= q_item.frame_end;
         opc_ff    <= q_item.opcode;
         fin_ff    <= q_item.fin;
         rsv_ff    <= q_item.rsv;
         err_ff    <= q_item.error_code;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data       = data_ff;
   assign rsp_data_valid = dvalid_ff;
   assign rsp_frame_end  = fend_ff;
   assign rsp_opcode     = opc_ff;
   assign rsp_fin        = fin_ff;
   assign rsp_rsv        = rsv_ff;
   assign rsp_error_code = err_ff;

   `WSDF_ASSERT(a_zero_data, (valid_ff && !dvalid_ff) |-> (data_ff == '0), "data set on a non-data result")
   `WSDF_ASSERT(a_err_no_data, (valid_ff && (err_ff != ERR_NONE)) |-> !dvalid_ff, "error result carries data")
   `WSDF_ASSERT(a_hold_stall, (valid_ff && rsp_stall) |=> valid_ff, "stalled result dropped")

endmodule
